// File: hdl/datetime_bcd_codec_weekday_defines.svh
// Assertion macros shared by the checker.
`ifndef DATETIME_BCD_CODEC_WEEKDAY_DEFINES_SVH
`define DATETIME_BCD_CODEC_WEEKDAY_DEFINES_SVH

// Same-cycle implication, sampled on i_clk, held off during reset.
`define DBCD_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on i_clk, held off during reset.
`define DBCD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// File: hdl/dbcd_pkg.sv
`timescale 1ns / 1ps
package dbcd_pkg;

    localparam int CFG_W     = 14;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_YEAR = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LAST_YEAR  = 2'd1;

    localparam logic [CFG_W-1:0] FIRST_YEAR_RST = 14'd2000;
    localparam logic [CFG_W-1:0] LAST_YEAR_RST  = 14'd2099;

    localparam logic KIND_ENCODE = 1'b0;
    localparam logic KIND_DECODE = 1'b1;

    // floor(x / 100) = (x * RECIP_100) >> RECIP_100_SH for x < 199728
    localparam logic [17:0] RECIP_100    = 18'd167773;
    localparam int          RECIP_100_SH = 24;
    // floor(x / 7) = (x * RECIP_7) >> RECIP_7_SH for x < 104857
    localparam logic [16:0] RECIP_7      = 17'd74899;
    localparam int          RECIP_7_SH   = 19;

    typedef struct packed {
        logic        kind;
        logic [7:0]  second_in;
        logic [7:0]  minute_in;
        logic [7:0]  hour_in;
        logic [7:0]  weekday_in;
        logic [7:0]  day_in;
        logic [7:0]  month_in;
        logic [15:0] year_in;
    } t_in_rec;

    typedef struct packed {
        logic        status;
        logic [6:0]  second_out;
        logic [6:0]  minute_out;
        logic [5:0]  hour_out;
        logic [2:0]  weekday_out;
        logic [5:0]  day_out;
        logic [4:0]  month_out;
        logic [15:0] year_out;
    } t_out_rec;

    typedef struct packed {
        logic [CFG_W-1:0] first_year;
        logic [CFG_W-1:0] last_year;
    } t_cfg;

    typedef struct packed {
        logic [6:0]  ds;
        logic [6:0]  dm;
        logic [5:0]  dh;
        logic [5:0]  dd;
        logic [4:0]  dmo;
        logic [13:0] dy;
    } t_dec_vals;

    typedef struct packed {
        t_in_rec   rec;
        logic [9:0] qy;
        t_dec_vals dec;
    } t_s1;

    typedef struct packed {
        t_in_rec    rec;
        logic       ok;
        logic [6:0] ry;
        logic [6:0] th;
        logic [3:0] hund;
        logic [16:0] wsum;
        t_dec_vals  dec;
    } t_s2;

    function automatic logic [6:0] f_div10(input logic [9:0] v);
        logic [17:0] p;
        p = 18'(v) * 18'd205;
        return p[17:11];
    endfunction

    function automatic logic [7:0] f_bcd2(input logic [7:0] v);
        logic [6:0] q;
        logic [7:0] r;
        q = f_div10({2'b00, v});
        r = v - 8'(q) * 8'd10;
        return {q[3:0], r[3:0]};
    endfunction

    function automatic logic [4:0] f_month_days(input logic [3:0] m);
        logic [4:0] d;
        unique case (m)
            4'd2:                      d = 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:   d = 5'd30;
            default:                   d = 5'd31;
        endcase
        return d;
    endfunction

    function automatic logic [2:0] f_wd_offset(input logic [3:0] m);
        logic [2:0] o;
        unique case (m)
            4'd2:    o = 3'd3;
            4'd3:    o = 3'd2;
            4'd4:    o = 3'd5;
            4'd6:    o = 3'd3;
            4'd7:    o = 3'd5;
            4'd8:    o = 3'd1;
            4'd9:    o = 3'd4;
            4'd10:   o = 3'd6;
            4'd11:   o = 3'd2;
            4'd12:   o = 3'd4;
            default: o = 3'd0;
        endcase
        return o;
    endfunction

endpackage

// File: hdl/dbcd_front.sv
`timescale 1ns / 1ps
module dbcd_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  dbcd_pkg::t_in_rec i_rec,
    output logic              o_valid,
    output dbcd_pkg::t_s1     o_s1
);
    import dbcd_pkg::*;

    logic        r_valid;
    logic        n_valid;
    t_s1         r_s1;
    t_s1         n_s1;
    logic [33:0] w_prod;

    always_comb begin
        w_prod        = 34'(i_rec.year_in) * 34'(RECIP_100);
        n_valid       = i_valid;
        n_s1.rec      = i_rec;
        n_s1.qy       = w_prod[RECIP_100_SH +: 10];
        n_s1.dec.ds   = 7'(i_rec.second_in[6:4]) * 7'd10 + 7'(i_rec.second_in[3:0]);
        n_s1.dec.dm   = 7'(i_rec.minute_in[6:4]) * 7'd10 + 7'(i_rec.minute_in[3:0]);
        n_s1.dec.dh   = 6'(i_rec.hour_in[5:4]) * 6'd10 + 6'(i_rec.hour_in[3:0]);
        n_s1.dec.dd   = 6'(i_rec.day_in[5:4]) * 6'd10 + 6'(i_rec.day_in[3:0]);
        n_s1.dec.dmo  = 5'(i_rec.month_in[4]) * 5'd10 + 5'(i_rec.month_in[3:0]);
        n_s1.dec.dy   = 14'(i_rec.year_in[14:12]) * 14'd1000
                      + 14'(i_rec.year_in[11:8]) * 14'd100
                      + 14'(i_rec.year_in[7:4]) * 14'd10
                      + 14'(i_rec.year_in[3:0]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1 <= n_s1;
    end

    assign o_valid = r_valid;
    assign o_s1    = r_s1;

endmodule

// File: hdl/dbcd_check.sv
`timescale 1ns / 1ps
module dbcd_check (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  dbcd_pkg::t_cfg i_cfg,
    input  logic          i_valid,
    input  dbcd_pkg::t_s1 i_s1,
    output logic          o_valid,
    output dbcd_pkg::t_s2 o_s2
);
    import dbcd_pkg::*;

    logic        r_valid;
    logic        n_valid;
    t_s2         r_s2;
    t_s2         n_s2;
    t_in_rec     w_rec;
    logic [15:0] w_qy100;
    logic [6:0]  w_ry;
    logic        w_leap;
    logic        w_mon_ok;
    logic [4:0]  w_lim;
    logic        w_enc_ok;
    logic        w_dec_ok;
    logic        w_early;
    logic [16:0] w_y17;
    logic [10:0] w_q100y;
    logic [6:0]  w_th;
    logic [15:0] w_first;
    logic [15:0] w_last;

    always_comb begin
        w_rec    = i_s1.rec;
        w_first  = 16'(i_cfg.first_year);
        w_last   = 16'(i_cfg.last_year);
        w_qy100  = 16'(i_s1.qy) * 16'd100;
        w_ry     = 7'(w_rec.year_in - w_qy100);
        w_leap   = (w_rec.year_in[1:0] == 2'd0) && ((w_ry != 7'd0) || (i_s1.qy[1:0] == 2'd0));
        w_mon_ok = (w_rec.month_in >= 8'd1) && (w_rec.month_in <= 8'd12);
        w_lim    = ((w_rec.month_in == 8'd2) && w_leap) ? 5'd29
                                                       : f_month_days(w_rec.month_in[3:0]);
        w_enc_ok = (w_rec.year_in >= w_first) && (w_rec.year_in <= w_last) && w_mon_ok
                && (w_rec.day_in != 8'd0) && (w_rec.day_in <= 8'(w_lim))
                && (w_rec.second_in <= 8'd59) && (w_rec.minute_in <= 8'd59)
                && (w_rec.hour_in <= 8'd23);
        w_dec_ok = (i_s1.dec.ds <= 7'd59) && (i_s1.dec.dm <= 7'd59)
                && (i_s1.dec.dh <= 6'd23) && (w_rec.weekday_in[2:0] != 3'd7)
                && (i_s1.dec.dd <= 6'd31) && (i_s1.dec.dmo >= 5'd1)
                && (i_s1.dec.dmo <= 5'd12) && (i_s1.dec.dy >= i_cfg.first_year)
                && (i_s1.dec.dy <= i_cfg.last_year);

        // January and February count against the previous year
        w_early  = w_rec.month_in < 8'd3;
        w_y17    = 17'(w_rec.year_in) + 17'd400 - 17'(w_early);
        w_q100y  = 11'(i_s1.qy) + 11'd4 - 11'(w_early && (w_ry == 7'd0));
        w_th     = f_div10(i_s1.qy);

        n_valid      = i_valid;
        n_s2.rec     = w_rec;
        n_s2.ok      = (w_rec.kind == KIND_ENCODE) ? w_enc_ok : w_dec_ok;
        n_s2.ry      = w_ry;
        n_s2.th      = w_th;
        n_s2.hund    = 4'(i_s1.qy - 10'(w_th) * 10'd10);
        n_s2.wsum    = w_y17 + (w_y17 >> 2) - 17'(w_q100y) + 17'(w_q100y >> 2)
                     + 17'(f_wd_offset(w_rec.month_in[3:0])) + 17'(w_rec.day_in);
        n_s2.dec     = i_s1.dec;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s2 <= n_s2;
    end

    assign o_valid = r_valid;
    assign o_s2    = r_s2;

endmodule

// File: hdl/dbcd_out.sv
`timescale 1ns / 1ps
module dbcd_out (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  dbcd_pkg::t_s2      i_s2,
    output logic               o_valid,
    output dbcd_pkg::t_out_rec o_res
);
    import dbcd_pkg::*;

    logic        r_valid;
    logic        n_valid;
    t_out_rec    r_res;
    t_out_rec    n_res;
    logic [33:0] w_p7;
    logic [14:0] w_q7;
    logic [2:0]  w_wd;
    logic [6:0]  w_tens;
    logic [3:0]  w_units;
    logic [7:0]  w_sec_bcd;
    logic [7:0]  w_min_bcd;
    logic [7:0]  w_hour_bcd;
    logic [7:0]  w_day_bcd;
    logic [7:0]  w_mon_bcd;

    always_comb begin
        w_p7       = 34'(i_s2.wsum) * 34'(RECIP_7);
        w_q7       = w_p7[RECIP_7_SH +: 15];
        w_wd       = 3'(i_s2.wsum - 17'(w_q7) * 17'd7);
        w_tens     = f_div10(10'(i_s2.ry));
        w_units    = 4'(i_s2.ry - w_tens * 7'd10);
        w_sec_bcd  = f_bcd2(i_s2.rec.second_in);
        w_min_bcd  = f_bcd2(i_s2.rec.minute_in);
        w_hour_bcd = f_bcd2(i_s2.rec.hour_in);
        w_day_bcd  = f_bcd2(i_s2.rec.day_in);
        w_mon_bcd  = f_bcd2(i_s2.rec.month_in);

        n_valid = i_valid;
        n_res   = '0;
        if (!i_s2.ok) begin
            n_res.status = 1'b1;
        end else if (i_s2.rec.kind == KIND_ENCODE) begin
            n_res.second_out  = w_sec_bcd[6:0];
            n_res.minute_out  = w_min_bcd[6:0];
            n_res.hour_out    = w_hour_bcd[5:0];
            n_res.weekday_out = w_wd;
            n_res.day_out     = w_day_bcd[5:0];
            n_res.month_out   = w_mon_bcd[4:0];
            n_res.year_out    = {1'b0, i_s2.th[2:0], i_s2.hund, w_tens[3:0], w_units};
        end else begin
            n_res.second_out  = i_s2.dec.ds;
            n_res.minute_out  = i_s2.dec.dm;
            n_res.hour_out    = i_s2.dec.dh;
            n_res.weekday_out = i_s2.rec.weekday_in[2:0];
            n_res.day_out     = i_s2.dec.dd;
            n_res.month_out   = i_s2.dec.dmo;
            n_res.year_out    = 16'(i_s2.dec.dy);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule

// File: hdl/datetime_bcd_codec_weekday.sv
// The o_valid strobe follows the accepting edge through the front, check and out stage registers.
// Throughput: one transaction per cycle; o_busy stays low, the receiver cannot stall.
// Stages: year/100 reciprocal multiply and BCD decode, range checks and weekday sum, mod-7 multiply and BCD encode.
// Reset: synchronous, active low; clears the stage valid bits and loads
// first_year 2000 and last_year 2099.
`timescale 1ns / 1ps
module datetime_bcd_codec_weekday (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_start,
    output logic                               o_busy,
    input  dbcd_pkg::t_in_rec                  i_rec,
    output logic                               o_valid,
    output dbcd_pkg::t_out_rec                 o_res,
    input  logic                               i_cfg_we,
    input  logic [dbcd_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [dbcd_pkg::CFG_W-1:0]         i_cfg_data
);
    import dbcd_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;
    logic w_accept;
    logic w_v1;
    logic w_v2;
    t_s1  w_s1;
    t_s2  w_s2;

    assign o_busy   = 1'b0;
    assign w_accept = i_start & ~o_busy;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_FIRST_YEAR: n_cfg.first_year = i_cfg_data;
                CFG_LAST_YEAR:  n_cfg.last_year  = i_cfg_data;
                default:        n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.first_year <= FIRST_YEAR_RST;
            r_cfg.last_year  <= LAST_YEAR_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    dbcd_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_accept),
        .i_rec   (i_rec),
        .o_valid (w_v1),
        .o_s1    (w_s1)
    );

    dbcd_check u_check (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (w_v1),
        .i_s1    (w_s1),
        .o_valid (w_v2),
        .o_s2    (w_s2)
    );

    dbcd_out u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_v2),
        .i_s2    (w_s2),
        .o_valid (o_valid),
        .o_res   (o_res)
    );

endmodule

// File: hdl/dbcd_checker.sv
`timescale 1ns / 1ps
`include "datetime_bcd_codec_weekday_defines.svh"
module dbcd_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_start,
    input logic               i_busy,
    input logic               i_valid,
    input dbcd_pkg::t_out_rec i_res
);
    import dbcd_pkg::*;

    logic w_fields_zero;

    assign w_fields_zero = ({i_res.second_out, i_res.minute_out, i_res.hour_out,
                             i_res.weekday_out, i_res.day_out, i_res.month_out,
                             i_res.year_out} == 50'd0);

    `DBCD_ASSERT_IMPL(a_latency, i_start && !i_busy, ##3 i_valid, "result strobe missing")
    `DBCD_ASSERT_IMPL(a_no_phantom, i_valid, $past(i_start && !i_busy, 3), "unrequested result")
    `DBCD_ASSERT_IMPL(a_err_zero, i_valid && i_res.status, w_fields_zero, "error result not cleared")
    `DBCD_ASSERT_IMPL(a_weekday, i_valid && !i_res.status, i_res.weekday_out != 3'd7, "bad weekday")
    `DBCD_ASSERT_NEXT(a_idle, !i_start, !i_busy, "busy without work")

endmodule

bind datetime_bcd_codec_weekday dbcd_checker u_dbcd_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_start (i_start),
    .i_busy  (o_busy),
    .i_valid (o_valid),
    .i_res   (o_res)
);
